>>> rtl/bba_pkg.sv
// Shared types, constants and sizing helpers for the buddy block allocator.
package bba_pkg;

    localparam int MaxBlocksDefault = 32;
    localparam int OrderW           = 5;
    localparam int ReqW             = 31;
    localparam int AddrW            = 30;
    localparam int StatusW          = 2;
    localparam int TotalOrderReset  = 10;
    localparam int OrderLimit       = 30;
    localparam int MaxFitOrder      = 31;
    localparam int InTdataW         = 32;
    localparam int OutTdataW        = 40;

    localparam logic [StatusW-1:0] ST_OK       = 2'd0;
    localparam logic [StatusW-1:0] ST_NO_FIT   = 2'd1;
    localparam logic [StatusW-1:0] ST_OVERFLOW = 2'd2;

    typedef struct packed {
        logic [OrderW-1:0] order;
        logic              used;
        logic [AddrW-1:0]  start;
    } t_entry;

    localparam int EntryW = $bits(t_entry);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_FIT, S_SCAN_RD, S_SCAN_CHK, S_PREP, S_CHECK,
        S_MOVE_RD, S_MOVE_WR, S_GRANT, S_PIECE, S_RES_OK, S_RES_NOFIT, S_RES_OVF
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE, OP_INIT, OP_LOAD, OP_FIT, OP_SCAN_CHK, OP_MARK, OP_PREP,
        OP_MOVE_WR, OP_GRANT, OP_PIECE, OP_RES_OK, OP_RES_NOFIT, OP_RES_OVF
    } t_op;

    typedef struct packed {
        logic fit_done;
        logic exact_hit;
        logic scan_last;
        logic big_found;
        logic overflow;
        logic need_move;
        logic move_done;
        logic piece_done;
        logic out_free;
    } t_status;

endpackage

>>> rtl/bba_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/bba_ctrl.sv
// Sequencing state machine for the buddy block allocator.
module bba_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wen,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  bba_pkg::t_status i_status,
    output bba_pkg::t_op     o_op
);

    bba_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bba_pkg::S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_op       = bba_pkg::OP_NONE;
        o_in_ready = 1'b0;
        unique case (r_state)
            bba_pkg::S_INIT: begin
                o_op    = bba_pkg::OP_INIT;
                n_state = bba_pkg::S_IDLE;
            end
            bba_pkg::S_IDLE: begin
                // Hold off the request while a total order write takes the cycle.
                o_in_ready = !i_cfg_wen;
                if (i_cfg_wen) begin
                    n_state = bba_pkg::S_INIT;
                end else if (i_in_valid) begin
                    o_op    = bba_pkg::OP_LOAD;
                    n_state = bba_pkg::S_FIT;
                end
            end
            bba_pkg::S_FIT: begin
                if (i_status.fit_done) begin
                    n_state = bba_pkg::S_SCAN_RD;
                end else begin
                    o_op = bba_pkg::OP_FIT;
                end
            end
            bba_pkg::S_SCAN_RD: begin
                n_state = bba_pkg::S_SCAN_CHK;
            end
            bba_pkg::S_SCAN_CHK: begin
                if (i_status.exact_hit) begin
                    o_op    = bba_pkg::OP_MARK;
                    n_state = bba_pkg::S_RES_OK;
                end else begin
                    o_op    = bba_pkg::OP_SCAN_CHK;
                    n_state = i_status.scan_last ? bba_pkg::S_PREP : bba_pkg::S_SCAN_RD;
                end
            end
            bba_pkg::S_PREP: begin
                if (i_status.big_found) begin
                    o_op    = bba_pkg::OP_PREP;
                    n_state = bba_pkg::S_CHECK;
                end else begin
                    n_state = bba_pkg::S_RES_NOFIT;
                end
            end
            bba_pkg::S_CHECK: begin
                priority if (i_status.overflow) begin
                    n_state = bba_pkg::S_RES_OVF;
                end else if (i_status.need_move) begin
                    n_state = bba_pkg::S_MOVE_RD;
                end else begin
                    n_state = bba_pkg::S_GRANT;
                end
            end
            bba_pkg::S_MOVE_RD: begin
                n_state = bba_pkg::S_MOVE_WR;
            end
            bba_pkg::S_MOVE_WR: begin
                o_op    = bba_pkg::OP_MOVE_WR;
                n_state = i_status.move_done ? bba_pkg::S_GRANT : bba_pkg::S_MOVE_RD;
            end
            bba_pkg::S_GRANT: begin
                o_op    = bba_pkg::OP_GRANT;
                n_state = bba_pkg::S_PIECE;
            end
            bba_pkg::S_PIECE: begin
                o_op = bba_pkg::OP_PIECE;
                if (i_status.piece_done) begin
                    n_state = bba_pkg::S_RES_OK;
                end
            end
            bba_pkg::S_RES_OK: begin
                if (i_status.out_free) begin
                    o_op    = bba_pkg::OP_RES_OK;
                    n_state = bba_pkg::S_IDLE;
                end
            end
            bba_pkg::S_RES_NOFIT: begin
                if (i_status.out_free) begin
                    o_op    = bba_pkg::OP_RES_NOFIT;
                    n_state = bba_pkg::S_IDLE;
                end
            end
            bba_pkg::S_RES_OVF: begin
                if (i_status.out_free) begin
                    o_op    = bba_pkg::OP_RES_OVF;
                    n_state = bba_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bba_pkg::S_INIT;
            end
        endcase
    end

endmodule

>>> rtl/bba_dp.sv
// Datapath: fit order, table scan, split moves and the result register.
module bba_dp #(
    parameter int MAX_BLOCKS = bba_pkg::MaxBlocksDefault
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wen,
    input  logic [bba_pkg::OrderW-1:0]          i_cfg_wdata,
    input  logic [bba_pkg::ReqW-1:0]            i_req,
    input  bba_pkg::t_op                        i_op,
    output bba_pkg::t_status                    o_status,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic                                o_granted,
    output logic [bba_pkg::StatusW-1:0]         o_res_status,
    output logic [bba_pkg::AddrW-1:0]           o_start
);

    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int SW = ((CW > bba_pkg::OrderW) ? CW : bba_pkg::OrderW) + 1;
    localparam int OW = bba_pkg::OrderW;
    localparam int AW = bba_pkg::AddrW;

    logic [OW-1:0]               r_total;
    logic [bba_pkg::ReqW-1:0]    r_req;
    logic [bba_pkg::ReqW:0]      r_pow;
    logic [OW-1:0]               r_f;
    logic [CW-1:0]               r_count;
    logic [CW-1:0]               r_i;
    logic                        r_big_found;
    logic [IW-1:0]               r_big_idx;
    logic [OW-1:0]               r_big_order;
    logic [AW-1:0]               r_big_start;
    logic [OW-1:0]               r_grow;
    logic [CW-1:0]               r_src;
    logic [OW-1:0]               r_j;
    logic [OW-1:0]               r_ord;
    logic [AW:0]                 r_addr;
    logic [AW:0]                 r_size;
    logic [AW-1:0]               r_res_start;
    logic                        r_out_valid;
    logic                        r_granted;
    logic [bba_pkg::StatusW-1:0] r_res_status;
    logic [AW-1:0]               r_start;

    logic                 ram_we;
    logic [IW-1:0]        ram_waddr;
    bba_pkg::t_entry      ram_wdata;
    logic [IW-1:0]        ram_raddr;
    bba_pkg::t_entry      ram_rdata;
    logic [SW-1:0]        need_sum;
    logic [SW-1:0]        dst_sum;
    logic [SW-1:0]        piece_sum;
    logic                 is_free;

    bba_ram #(
        .WIDTH (bba_pkg::EntryW),
        .DEPTH (MAX_BLOCKS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign is_free   = !ram_rdata.used;
    assign need_sum  = SW'(r_count) + SW'(r_grow);
    assign dst_sum   = SW'(r_src) + SW'(r_grow);
    assign piece_sum = SW'(r_big_idx) + SW'(r_j);
    // During moves r_i tracks the source entry, so one read index serves both loops.
    assign ram_raddr = r_i[IW-1:0];

    always_comb begin
        o_status.fit_done   = !((r_f < OW'(bba_pkg::MaxFitOrder)) &&
                                (r_pow < {1'b0, r_req}));
        o_status.exact_hit  = is_free && (ram_rdata.order == r_f);
        o_status.scan_last  = (r_i == r_count - CW'(1));
        o_status.big_found  = r_big_found;
        o_status.overflow   = need_sum > SW'(MAX_BLOCKS);
        o_status.need_move  = r_src > CW'(r_big_idx);
        o_status.move_done  = (r_src - CW'(1)) == CW'(r_big_idx);
        o_status.piece_done = (r_j == r_grow);
        o_status.out_free   = !r_out_valid || i_out_ready;
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_i[IW-1:0];
        ram_wdata = ram_rdata;
        unique case (i_op)
            bba_pkg::OP_INIT: begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = '{order: r_total, used: 1'b0, start: '0};
            end
            bba_pkg::OP_MARK: begin
                ram_we         = 1'b1;
                ram_wdata.used = 1'b1;
            end
            bba_pkg::OP_MOVE_WR: begin
                ram_we    = 1'b1;
                ram_waddr = dst_sum[IW-1:0];
            end
            bba_pkg::OP_GRANT: begin
                ram_we    = 1'b1;
                ram_waddr = r_big_idx;
                ram_wdata = '{order: r_f, used: 1'b1, start: r_addr[AW-1:0]};
            end
            bba_pkg::OP_PIECE: begin
                ram_we    = 1'b1;
                ram_waddr = piece_sum[IW-1:0];
                ram_wdata = '{order: r_ord, used: 1'b0, start: r_addr[AW-1:0]};
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Control state: configured order, table fill count, result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= OW'(bba_pkg::TotalOrderReset);
            r_count     <= CW'(1);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wen) begin
                r_total <= (i_cfg_wdata > OW'(bba_pkg::OrderLimit)) ?
                           OW'(bba_pkg::OrderLimit) : i_cfg_wdata;
            end
            if (i_op == bba_pkg::OP_INIT) begin
                r_count <= CW'(1);
            end else if (i_op == bba_pkg::OP_PIECE && r_j == r_grow) begin
                r_count <= need_sum[CW-1:0];
            end
            if (i_op == bba_pkg::OP_RES_OK || i_op == bba_pkg::OP_RES_NOFIT ||
                i_op == bba_pkg::OP_RES_OVF) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_op)
            bba_pkg::OP_LOAD: begin
                r_req       <= i_req;
                r_pow       <= (bba_pkg::ReqW+1)'(2);
                r_f         <= OW'(1);
                r_i         <= '0;
                r_src       <= '0;
                r_big_found <= 1'b0;
            end
            bba_pkg::OP_FIT: begin
                r_pow <= {r_pow[bba_pkg::ReqW-1:0], 1'b0};
                r_f   <= r_f + OW'(1);
            end
            bba_pkg::OP_SCAN_CHK: begin
                if (is_free && ram_rdata.order > r_f && !r_big_found) begin
                    r_big_found <= 1'b1;
                    r_big_idx   <= r_i[IW-1:0];
                    r_big_order <= ram_rdata.order;
                    r_big_start <= ram_rdata.start;
                end
                r_i <= r_i + CW'(1);
            end
            bba_pkg::OP_MARK: begin
                r_res_start <= ram_rdata.start;
            end
            bba_pkg::OP_PREP: begin
                r_grow <= r_big_order - r_f;
                r_src  <= r_count - CW'(1);
                r_i    <= r_count - CW'(1);
                r_addr <= {1'b0, r_big_start};
            end
            bba_pkg::OP_MOVE_WR: begin
                // Walk the source down; read address follows on the next cycle.
                r_src <= r_src - CW'(1);
                r_i   <= r_src - CW'(1);
            end
            bba_pkg::OP_GRANT: begin
                r_res_start <= r_addr[AW-1:0];
                r_size      <= r_pow[AW:0];
                r_addr      <= r_addr + r_pow[AW:0];
                r_ord       <= r_f;
                r_j         <= OW'(1);
            end
            bba_pkg::OP_PIECE: begin
                // Each free piece is as large as everything before it in the block.
                r_addr <= r_addr + r_size;
                r_size <= {r_size[AW-1:0], 1'b0};
                r_ord  <= r_ord + OW'(1);
                r_j    <= r_j + OW'(1);
            end
            bba_pkg::OP_RES_OK: begin
                r_granted    <= 1'b1;
                r_res_status <= bba_pkg::ST_OK;
                r_start      <= r_res_start;
            end
            bba_pkg::OP_RES_NOFIT: begin
                r_granted    <= 1'b0;
                r_res_status <= bba_pkg::ST_NO_FIT;
                r_start      <= '0;
            end
            bba_pkg::OP_RES_OVF: begin
                r_granted    <= 1'b0;
                r_res_status <= bba_pkg::ST_OVERFLOW;
                r_start      <= '0;
            end
            default: begin
                r_req <= r_req;
            end
        endcase
    end

    assign o_out_valid  = r_out_valid;
    assign o_granted    = r_granted;
    assign o_res_status = r_res_status;
    assign o_start      = r_start;

endmodule

>>> rtl/buddy_block_allocator.sv
// From accept to result valid: the fit order is found step by step, then table entries
// are scanned by a read/check state pair; with no exact fit the whole table is scanned
// and the result is no fit, overflow, or a split that moves entries and writes pieces.
// Requests are taken one at a time, a new one only back in idle after the result,
// paced by the read/check loop over the single-read-port table memory.
// Reset (synchronous, active low) and a total_order write taken while idle rewrite
// the table as the single free head block before the next request is taken.
module buddy_block_allocator #(
    parameter int MAX_BLOCKS = bba_pkg::MaxBlocksDefault
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wen,
    input  logic [bba_pkg::OrderW-1:0]        i_cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [bba_pkg::InTdataW-1:0]      s_axis_tdata,  // [30:0] request_size
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [bba_pkg::OutTdataW-1:0]     m_axis_tdata   // [0] granted, [2:1] status,
                                                             // [32:3] start_address
);

    bba_pkg::t_op                op;
    bba_pkg::t_status            status;
    logic                        granted;
    logic [bba_pkg::StatusW-1:0] res_status;
    logic [bba_pkg::AddrW-1:0]   start;

    bba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_wen  (i_cfg_wen),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_op       (op)
    );

    bba_dp #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wen    (i_cfg_wen),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_req        (s_axis_tdata[bba_pkg::ReqW-1:0]),
        .i_op         (op),
        .o_status     (status),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_granted    (granted),
        .o_res_status (res_status),
        .o_start      (start)
    );

    assign m_axis_tdata = {7'd0, start, res_status, granted};

endmodule

>>> rtl/bba_checker.sv
// Port-level checker for the buddy block allocator, bound to the top level.
module bba_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata
);

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[39:33] == 7'd0))
        else $error("result padding bits not zero");

    a_grant_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[0]) |-> (m_axis_tdata[2:1] == 2'd0))
        else $error("grant with nonzero status");

    a_deny: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tdata[0]) |->
        ((m_axis_tdata[32:3] == 30'd0) &&
         (m_axis_tdata[2:1] == 2'd1 || m_axis_tdata[2:1] == 2'd2)))
        else $error("denied transaction with bad status or address");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind buddy_block_allocator bba_checker u_bba_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
